// ===== src/wfd_pkg.sv =====
// ----------------------------------------------------------------------------
// wfd_pkg
// Shared types and codes of the frame deframer and its port checker.
// ----------------------------------------------------------------------------
package wfd_pkg;

   localparam int DEF_LENGTH_WIDTH = 32;

   localparam int BYTE_W     = 8;
   localparam int LEN_OUT_W  = 32;
   localparam int CFG_W      = 32;
   localparam int ACC_W      = 64;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = 4;
   localparam int KIND_W     = 2;
   localparam int ERR_W      = 3;

   // Bit positions inside rsp_tdata / rsp_tuser
   localparam int LEN_LSB  = 0;
   localparam int DATA_LSB = 32;
   localparam int ERR_LSB  = 40;
   localparam int RK_LSB   = 0;
   localparam int MK_LSB   = 2;

   typedef enum logic [KIND_W-1:0] {
      RK_HEADER  = 2'd0,
      RK_PAYLOAD = 2'd1,
      RK_ERROR   = 2'd2
   } result_kind_type;

   typedef enum logic [KIND_W-1:0] {
      MK_TEXT   = 2'd0,
      MK_BINARY = 2'd1,
      MK_PING   = 2'd2
   } message_kind_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE      = 3'd0,
      ERR_CONTINUE  = 3'd1,
      ERR_OPCODE    = 3'd2,
      ERR_TOO_LONG  = 3'd3,
      ERR_TRUNCATED = 3'd4
   } error_code_type;

   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_PING   = 4'h9;

   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;

   localparam logic [2:0] EXT16_BYTES = 3'd2;
   localparam logic [2:0] EXT64_BYTES = 3'd0;  // eight bytes: count wraps through zero
   localparam logic [2:0] MASK_BYTES  = 3'd4;

endpackage

// ===== src/websocket_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Parses one frame header per read, checks it and streams unmasked payload.
// ----------------------------------------------------------------------------
// Each result is registered and appears on rsp_* in the cycle after its request is accepted.
// Throughput: one request per cycle; the single result register stalls
//   req_tready only while a result waits and rsp_tready is low.
// Reset: synchronous, active high; parser returns to the first header byte,
//   max_payload_length returns to all ones, no result pending.
// ----------------------------------------------------------------------------
module websocket_frame_deframer #(
   parameter int LENGTH_WIDTH = wfd_pkg::DEF_LENGTH_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [wfd_pkg::CFG_W-1:0]       csr_wr_data,   // max_payload_length
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [wfd_pkg::REQ_DATA_W-1:0]  req_tdata,     // [7:0] rx_byte
   input  logic                            req_tlast,     // end_of_read
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [31:0] declared_length, [39:32] payload_data, [42:40] error_code, rest 0
   output logic [wfd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // [1:0] result_kind, [3:2] message_kind
   output logic [wfd_pkg::RSP_USER_W-1:0]  rsp_tuser,
   output logic                            rsp_tlast      // last_of_frame
);
   import wfd_pkg::*;

   localparam int IDX_W = (LENGTH_WIDTH < 32) ? LENGTH_WIDTH : 32;
   localparam logic [ACC_W-1:0] LEN_LIMIT =
      (LENGTH_WIDTH >= ACC_W) ? {ACC_W{1'b1}} : ((ACC_W'(1) << LENGTH_WIDTH) - ACC_W'(1));

   typedef enum logic [2:0] {
      PH_HDR0, PH_HDR1, PH_EXTLEN, PH_MASK, PH_PAYLOAD, PH_DISCARD
   } phase_type;

   phase_type               phase_ff, phase_in;
   message_kind_type        ftype_ff, ftype_in;
   logic                    mask_on_ff, mask_on_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic [2:0]              hcnt_ff, hcnt_in;
   logic [31:0]             mkey_ff, mkey_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [CFG_W-1:0]        max_len_ff;

   logic                    rsp_valid_ff;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0]   rsp_user_ff, rsp_user_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    accept;
   logic                    res_vld;
   result_kind_type         res_kind;
   error_code_type          res_err;
   logic [BYTE_W-1:0]       res_data;
   logic                    res_last;
   logic                    len_done, hdr_done, too_long;
   logic [BYTE_W-1:0]       mask_byte;
   logic [IDX_W:0]          idx_inc;
   logic [3:0]              opcode;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign opcode   = req_tdata[3:0];
   assign idx_inc  = {1'b0, idx_ff} + (IDX_W+1)'(1);

   always_comb begin
      unique case (idx_ff[1:0])
         2'd0:    mask_byte = mkey_ff[31:24];
         2'd1:    mask_byte = mkey_ff[23:16];
         2'd2:    mask_byte = mkey_ff[15:8];
         default: mask_byte = mkey_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in   = phase_ff;
      ftype_in   = ftype_ff;
      mask_on_in = mask_on_ff;
      acc_in     = acc_ff;
      hcnt_in    = hcnt_ff;
      mkey_in    = mkey_ff;
      idx_in     = idx_ff;
      res_vld    = 1'b0;
      res_kind   = RK_HEADER;
      res_err    = ERR_NONE;
      res_data   = '0;
      res_last   = 1'b0;
      len_done   = 1'b0;
      hdr_done   = 1'b0;
      too_long   = 1'b0;

      unique case (phase_ff)
         PH_HDR0: begin
            if (!req_tdata[7]) begin
               phase_in = PH_DISCARD;
               res_vld  = 1'b1;
               res_kind = RK_ERROR;
               res_err  = ERR_CONTINUE;
            end else if (opcode == OP_TEXT || opcode == OP_BINARY || opcode == OP_PING) begin
               ftype_in = (opcode == OP_TEXT)   ? MK_TEXT :
                          (opcode == OP_BINARY) ? MK_BINARY : MK_PING;
               phase_in = PH_HDR1;
            end else begin
               phase_in = PH_DISCARD;
               res_vld  = 1'b1;
               res_kind = RK_ERROR;
               res_err  = ERR_OPCODE;
            end
         end
         PH_HDR1: begin
            mask_on_in = req_tdata[7];
            acc_in     = '0;
            if (req_tdata[6:0] == LEN7_EXT16) begin
               hcnt_in  = EXT16_BYTES;
               phase_in = PH_EXTLEN;
            end else if (req_tdata[6:0] == LEN7_EXT64) begin
               hcnt_in  = EXT64_BYTES;
               phase_in = PH_EXTLEN;
            end else begin
               acc_in   = ACC_W'(req_tdata[6:0]);
               len_done = 1'b1;
            end
         end
         PH_EXTLEN: begin
            acc_in   = {acc_ff[ACC_W-BYTE_W-1:0], req_tdata};
            hcnt_in  = hcnt_ff - 3'd1;
            len_done = (hcnt_in == 3'd0);
         end
         PH_MASK: begin
            mkey_in  = {mkey_ff[23:0], req_tdata};
            hcnt_in  = hcnt_ff - 3'd1;
            hdr_done = (hcnt_in == 3'd0);
         end
         PH_PAYLOAD: begin
            res_vld  = 1'b1;
            res_kind = RK_PAYLOAD;
            res_data = mask_on_ff ? (req_tdata ^ mask_byte) : req_tdata;
            idx_in   = idx_inc[IDX_W-1:0];
            // length is nonzero and fits the index here, so equality marks the end
            res_last = (idx_inc == acc_ff[IDX_W:0]);
            if (res_last) begin
               phase_in = PH_DISCARD;
            end
         end
         default: begin
            phase_in = PH_DISCARD;
         end
      endcase

      if (len_done) begin
         too_long = (acc_in > LEN_LIMIT) ||
                    (acc_in > {{(ACC_W-CFG_W){1'b0}}, max_len_ff});
         if (too_long) begin
            phase_in = PH_DISCARD;
            res_vld  = 1'b1;
            res_kind = RK_ERROR;
            res_err  = ERR_TOO_LONG;
         end else if (mask_on_in) begin
            phase_in = PH_MASK;
            hcnt_in  = MASK_BYTES;
         end else begin
            hdr_done = 1'b1;
         end
      end

      if (hdr_done) begin
         idx_in   = '0;
         res_vld  = 1'b1;
         res_kind = RK_HEADER;
         res_last = (acc_in == '0);
         phase_in = res_last ? PH_DISCARD : PH_PAYLOAD;
      end

      // a read that ends mid-frame replaces this byte's result
      if (req_tlast && phase_in != PH_DISCARD && phase_in != PH_HDR0) begin
         res_vld  = 1'b1;
         res_kind = RK_ERROR;
         res_err  = ERR_TRUNCATED;
         res_data = '0;
         res_last = 1'b0;
      end

      rsp_data_in = '0;
      rsp_data_in[LEN_LSB +: LEN_OUT_W] = acc_in[LEN_OUT_W-1:0];
      rsp_data_in[DATA_LSB +: BYTE_W]   = res_data;
      rsp_data_in[ERR_LSB +: ERR_W]     = res_err;
      rsp_user_in = {ftype_in, res_kind};
      rsp_last_in = res_last;

      if (req_tlast) begin
         phase_in   = PH_HDR0;
         ftype_in   = MK_TEXT;
         mask_on_in = 1'b0;
         acc_in     = '0;
         hcnt_in    = '0;
         mkey_in    = '0;
         idx_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && res_vld) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
         rsp_last_ff <= rsp_last_in;
      end
      if (reset) begin
         phase_ff     <= PH_HDR0;
         ftype_ff     <= MK_TEXT;
         mask_on_ff   <= 1'b0;
         acc_ff       <= '0;
         hcnt_ff      <= '0;
         mkey_ff      <= '0;
         idx_ff       <= '0;
         max_len_ff   <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
         if (accept) begin
            phase_ff   <= phase_in;
            ftype_ff   <= ftype_in;
            mask_on_ff <= mask_on_in;
            acc_ff     <= acc_in;
            hcnt_ff    <= hcnt_in;
            mkey_ff    <= mkey_in;
            idx_ff     <= idx_in;
         end
         // hold the result until taken; load a new one on any request that makes one
         if (accept) begin
            rsp_valid_ff <= res_vld;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== src/wfd_checker.sv =====
// ----------------------------------------------------------------------------
// wfd_checker
// Port-level checks of the frame deframer, bound into the deframer module.
// ----------------------------------------------------------------------------
module wfd_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [wfd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic [wfd_pkg::RSP_USER_W-1:0]  rsp_tuser,
   input  logic                            rsp_tlast
);
   import wfd_pkg::*;

   logic [KIND_W-1:0] rkind;
   logic [ERR_W-1:0]  ecode;

   assign rkind = rsp_tuser[RK_LSB +: KIND_W];
   assign ecode = rsp_tdata[ERR_LSB +: ERR_W];

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
         $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // a new result needs a request accepted on the edge before
   a_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !$past(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("result without request");

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rkind != RK_ERROR |-> ecode == ERR_NONE)
      else $error("error code on a non-error result");

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rkind == RK_ERROR |-> !rsp_tlast &&
         (ecode == ERR_CONTINUE || ecode == ERR_OPCODE ||
          ecode == ERR_TOO_LONG || ecode == ERR_TRUNCATED))
      else $error("malformed error result");

endmodule

bind websocket_frame_deframer wfd_checker u_wfd_checker (.*);

// ===== sim/tb_websocket_frame_deframer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_websocket_frame_deframer
// Feeds socket reads byte by byte into the frame deframer and compares every
// header, payload and error response with an untimed predictor of the parser.
// Directed reads cover each opcode and each error. Random reads are mostly
// well-formed frames with random lengths, masks and cuts, plus noise. Both
// stream sides idle at random, and the length limit changes between phases.
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer;
   import wfd_pkg::*;

   localparam int QUIET_LIMIT  = 1000;
   localparam int PHASE_BYTES  = 180;
   localparam int PHASE_COUNT  = 7;

   typedef enum logic [2:0] {
      PH_HEADER0,
      PH_HEADER1,
      PH_EXT_LENGTH,
      PH_MASK_KEY,
      PH_PAYLOAD,
      PH_DISCARD
   } parse_phase_type;

   typedef struct {
      result_kind_type      kind;
      message_kind_type     msg;
      logic [LEN_OUT_W-1:0] length;
      logic [BYTE_W-1:0]    data;
      error_code_type       err;
      logic                 last;
   } deframe_result_type;

   class deframe_scoreboard;
      parse_phase_type    phase;
      message_kind_type   frame_kind;
      logic               masked;
      logic [ACC_W-1:0]   length_acc;
      logic [2:0]         bytes_left;
      logic [31:0]        mask_key;
      logic [31:0]        payload_count;
      logic [CFG_W-1:0]   max_length;
      deframe_result_type expected_q[$];
      int                 errors;

      function new();
         max_length = '1;
         errors = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         phase = PH_HEADER0;
         frame_kind = MK_TEXT;
         masked = 1'b0;
         length_acc = '0;
         bytes_left = '0;
         mask_key = '0;
         payload_count = '0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function deframe_result_type make_result(result_kind_type k, logic [7:0] d,
                                               error_code_type e, logic l);
         deframe_result_type r;
         r.kind = k;
         r.msg = frame_kind;
         r.length = length_acc[LEN_OUT_W-1:0];
         r.data = d;
         r.err = e;
         r.last = l;
         return r;
      endfunction

      // header complete: payload follows unless the frame is empty
      function deframe_result_type close_header();
         payload_count = '0;
         if (length_acc == 0) begin
            phase = PH_DISCARD;
            return make_result(RK_HEADER, '0, ERR_NONE, 1'b1);
         end
         phase = PH_PAYLOAD;
         return make_result(RK_HEADER, '0, ERR_NONE, 1'b0);
      endfunction

      // length complete: check the limit, then collect the key or close the header
      function bit close_length(output deframe_result_type r);
         if ((length_acc >> DEF_LENGTH_WIDTH) != 0 || length_acc > ACC_W'(max_length)) begin
            phase = PH_DISCARD;
            r = make_result(RK_ERROR, '0, ERR_TOO_LONG, 1'b0);
            return 1'b1;
         end
         if (masked) begin
            phase = PH_MASK_KEY;
            bytes_left = MASK_BYTES;
            return 1'b0;
         end
         r = close_header();
         return 1'b1;
      endfunction

      function void note_request(logic [7:0] octet, logic eor);
         deframe_result_type r;
         bit                 fired;
         logic [7:0]         plain;
         int                 key_sel;
         fired = 1'b0;
         case (phase)
            PH_HEADER0: begin
               if (!octet[7]) begin
                  phase = PH_DISCARD;
                  r = make_result(RK_ERROR, '0, ERR_CONTINUE, 1'b0);
                  fired = 1'b1;
               end else if (octet[3:0] == OP_TEXT || octet[3:0] == OP_BINARY ||
                            octet[3:0] == OP_PING) begin
                  if (octet[3:0] == OP_TEXT) frame_kind = MK_TEXT;
                  else if (octet[3:0] == OP_BINARY) frame_kind = MK_BINARY;
                  else frame_kind = MK_PING;
                  phase = PH_HEADER1;
               end else begin
                  phase = PH_DISCARD;
                  r = make_result(RK_ERROR, '0, ERR_OPCODE, 1'b0);
                  fired = 1'b1;
               end
            end
            PH_HEADER1: begin
               masked = octet[7];
               length_acc = '0;
               if (octet[6:0] == LEN7_EXT16) begin
                  bytes_left = EXT16_BYTES;
                  phase = PH_EXT_LENGTH;
               end else if (octet[6:0] == LEN7_EXT64) begin
                  bytes_left = EXT64_BYTES;
                  phase = PH_EXT_LENGTH;
               end else begin
                  length_acc = ACC_W'(octet[6:0]);
                  fired = close_length(r);
               end
            end
            PH_EXT_LENGTH: begin
               length_acc = {length_acc[ACC_W-9:0], octet};
               bytes_left = bytes_left - 3'd1;
               if (bytes_left == 0) fired = close_length(r);
            end
            PH_MASK_KEY: begin
               mask_key = {mask_key[23:0], octet};
               bytes_left = bytes_left - 3'd1;
               if (bytes_left == 0) begin
                  r = close_header();
                  fired = 1'b1;
               end
            end
            PH_PAYLOAD: begin
               plain = octet;
               // key bytes apply most significant first
               key_sel = 3 - int'(payload_count[1:0]);
               if (masked) plain = plain ^ mask_key[8*key_sel +: 8];
               payload_count = payload_count + 32'd1;
               if (ACC_W'(payload_count) >= length_acc) begin
                  phase = PH_DISCARD;
                  r = make_result(RK_PAYLOAD, plain, ERR_NONE, 1'b1);
               end else begin
                  r = make_result(RK_PAYLOAD, plain, ERR_NONE, 1'b0);
               end
               fired = 1'b1;
            end
            default: phase = PH_DISCARD;
         endcase
         // a read ending inside a frame overrides whatever this byte produced
         if (eor) begin
            if (phase != PH_DISCARD && phase != PH_HEADER0) begin
               r = make_result(RK_ERROR, '0, ERR_TRUNCATED, 1'b0);
               fired = 1'b1;
            end
            clear_frame();
         end
         if (fired) expected_q.push_back(r);
      endfunction

      task report(string field, logic [63:0] got, logic [63:0] want);
         $display("%0t mismatch on %s: got %0h, want %0h", $realtime, field, got, want);
         errors++;
      endtask

      task check_result(logic [RSP_DATA_W-1:0] tdata, logic [RSP_USER_W-1:0] tuser,
                        logic tlast);
         deframe_result_type w;
         if (expected_q.size() == 0) begin
            report("response with none outstanding", 64'(tdata), 64'd0);
            return;
         end
         w = expected_q.pop_front();
         if (tuser[RK_LSB +: KIND_W] !== w.kind)
            report("result_kind", 64'(tuser[RK_LSB +: KIND_W]), 64'(w.kind));
         if (tuser[MK_LSB +: KIND_W] !== w.msg)
            report("message_kind", 64'(tuser[MK_LSB +: KIND_W]), 64'(w.msg));
         if (tdata[LEN_LSB +: LEN_OUT_W] !== w.length)
            report("declared_length", 64'(tdata[LEN_LSB +: LEN_OUT_W]), 64'(w.length));
         if (tdata[DATA_LSB +: BYTE_W] !== w.data)
            report("payload_data", 64'(tdata[DATA_LSB +: BYTE_W]), 64'(w.data));
         if (tdata[ERR_LSB +: ERR_W] !== w.err)
            report("error_code", 64'(tdata[ERR_LSB +: ERR_W]), 64'(w.err));
         if (tlast !== w.last)
            report("last_of_frame", 64'(tlast), 64'(w.last));
      endtask
   endclass

   logic                    clock;
   logic                    reset;
   logic                    csr_wr_en;
   logic [CFG_W-1:0]        csr_wr_data;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;    // [7:0] rx_byte
   logic                    req_tlast;    // end_of_read
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;    // [31:0] length, [39:32] data, [42:40] error
   logic [RSP_USER_W-1:0]   rsp_tuser;    // [1:0] result_kind, [3:2] message_kind
   logic                    rsp_tlast;    // last_of_frame

   deframe_scoreboard sb;
   bit                steady;
   bit                finished;
   int                quiet_cycles;

   websocket_frame_deframer dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   // result side: ready stretches broken by stalls, none in steady phases
   initial begin
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         if (!steady) begin
            rsp_tready <= 1'b0;
            repeat (pick_gap()) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && !finished) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
         if (req_tvalid && req_tready) sb.note_request(req_tdata, req_tlast);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // one read: the last request carries the end-of-read flag
   task automatic send_octets(input logic [7:0] octets[$]);
      foreach (octets[i]) begin
         if (!steady && $urandom_range(0, 3) == 0) begin
            req_tvalid <= 1'b0;
            repeat (pick_gap()) @(posedge clock);
         end
         req_tdata <= octets[i];
         req_tlast <= (i == octets.size() - 1);
         req_tvalid <= 1'b1;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
      end
   endtask

   task automatic send_read(output int sent);
      logic [7:0]  octets[$];
      logic [63:0] declared;
      logic [3:0]  op;
      logic        fin;
      logic        masked;
      int          roll;
      int          enc;
      int          body;
      int          cut;
      int          k;
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
         repeat ($urandom_range(1, 8)) octets.push_back(8'($urandom_range(0, 255)));
      end else begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4:    op = OP_TEXT;
            5, 6, 7, 8, 9:    op = OP_BINARY;
            10, 11, 12, 13, 14, 15, 16: op = OP_PING;
            default:          op = 4'($urandom_range(0, 15));
         endcase
         fin = ($urandom_range(0, 19) != 0);
         masked = 1'($urandom_range(0, 1));
         octets.push_back({fin, 3'($urandom_range(0, 7)), op});
         roll = $urandom_range(0, 99);
         if (roll < 65) declared = 64'($urandom_range(0, 12));
         else if (roll < 80) declared = 64'($urandom_range(13, 60));
         else if (roll < 88) declared = 64'($urandom_range(61, 65535));
         else if (roll < 94) declared = 64'($urandom_range(61, 32'hFFFF_FFFF));
         else declared = {$urandom, $urandom};
         enc = $urandom_range(0, 9);
         if (declared < 126 && enc < 7) begin
            octets.push_back({masked, declared[6:0]});
         end else if (declared < 65536 && enc < 9) begin
            octets.push_back({masked, LEN7_EXT16});
            octets.push_back(declared[15:8]);
            octets.push_back(declared[7:0]);
         end else begin
            octets.push_back({masked, LEN7_EXT64});
            for (k = 7; k >= 0; k--) octets.push_back(declared[8*k +: 8]);
         end
         if (masked) repeat (4) octets.push_back(8'($urandom_range(0, 255)));
         // big frames never finish: send a few bytes and let the read cut them
         body = (declared <= 60) ? int'(declared) : $urandom_range(0, 6);
         repeat (body) octets.push_back(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 9) < 2) begin
            cut = $urandom_range(1, octets.size() - 1);
            octets = octets[0:cut-1];
         end else if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) octets.push_back(8'($urandom_range(0, 255)));
         end
      end
      send_octets(octets);
      sent = octets.size();
   endtask

   // drain, let the last request settle, then load a new length limit
   task automatic write_limit(input logic [CFG_W-1:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.max_length = value;
   endtask

   initial begin
      logic [7:0]       dir[$];
      logic [CFG_W-1:0] limits[PHASE_COUNT];
      int               budget;
      int               n;
      int               p;
      sb = new();
      steady = 1'b0;
      finished = 1'b0;
      quiet_cycles = 0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      dir = {8'h81, 8'h00};                 // empty text frame
      send_octets(dir);
      dir = {8'h01};                        // FIN clear
      send_octets(dir);
      dir = {8'h83};                        // unsupported opcode
      send_octets(dir);
      dir = {8'h82, 8'h81, 8'hA5, 8'h5A, 8'hFF, 8'h00, 8'h3C};   // masked binary
      send_octets(dir);
      dir = {8'h89, 8'h7E, 8'h00, 8'h01, 8'hFF};                  // ping, 16-bit length
      send_octets(dir);
      dir = {8'h82, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00};
      send_octets(dir);                     // 64-bit length past the width
      dir = {8'h81, 8'h05, 8'h41};          // read ends inside the payload
      send_octets(dir);

      limits[0] = '1;
      limits[1] = '0;
      limits[2] = 32'd5;
      limits[3] = 32'd40 + CFG_W'($urandom_range(0, 20));
      limits[4] = $urandom;
      limits[5] = 32'd1;
      limits[6] = '1;
      for (p = 0; p < PHASE_COUNT; p++) begin
         steady = (p % 3 == 2);
         write_limit(limits[p]);
         budget = 0;
         while (budget < PHASE_BYTES) begin
            send_read(n);
            budget += n;
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      finished <= 1'b1;
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
